/* design/crs_pkg.sv */
// Package for the command retry scheduler: field widths, codes and entry record.
// No dependencies.
package crs_pkg;
    localparam int DEPTH_DEF = 16;
    localparam logic [15:0] TIMEOUT_RST = 16'd30;
    localparam logic [3:0]  RETRY_RST   = 4'd3;

    typedef enum logic [1:0] {
        F_LOAD = 2'd0, F_REPORT = 2'd1, F_TICK = 2'd2, F_RECONNECT = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        K_SEND = 2'd0, K_RESEND = 2'd1, K_DONE = 2'd2
    } t_kind;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_RETRY   = 1'b1;

    typedef struct packed {
        logic        done;
        logic        sent;
        logic [7:0]  number;
        logic [7:0]  atype;
        logic [15:0] payload;
        logic [15:0] order;
        logic [15:0] stamp;
        logic [7:0]  sends;
        logic [3:0]  timeouts;
    } t_entry;
endpackage

/* design/crs_if.sv */
// Valid/ready channel interfaces for items, results and configuration writes.
// Depends on nothing.
interface crs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] cmd_num;
    logic [7:0] action_type;
    logic [15:0] payload_ref;
    logic       last;
    logic       finished;
    modport source (output valid, func, cmd_num, action_type, payload_ref,
                    last, finished, input ready);
    modport sink (input valid, func, cmd_num, action_type, payload_ref,
                  last, finished, output ready);
endinterface

interface crs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] sent_number;
    logic [15:0] sent_payload;
    logic [7:0] running_type;
    logic [7:0] times_sent;
    logic [4:0] entry_count;
    modport source (output valid, kind, sent_number, sent_payload, running_type,
                    times_sent, entry_count, input ready);
    modport sink (input valid, kind, sent_number, sent_payload, running_type,
                  times_sent, entry_count, output ready);
endinterface

interface crs_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* design/crs_table.sv */
// Entry memory: one synchronous read port, one write port, registered read data.
// Depends on crs_pkg.
module crs_table #(
    parameter int DEPTH = crs_pkg::DEPTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic [AW-1:0]         i_raddr,
    output crs_pkg::t_entry       o_rdata,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  crs_pkg::t_entry       i_wdata
);
    import crs_pkg::*;
    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

/* design/command_retry_scheduler.sv */
// Command retry scheduler. Usage:
//   Items enter on u_in (func load/report/tick/reconnect); results leave on
//   u_out (send, resend, batch done); u_cfg writes timeout_ticks (index 0)
//   and max_retries (index 1). The user must write them only while the
//   block is idle; the block itself does not enforce it. Entries live in a
//   single-port-read memory of DEPTH words; valid bits are flip-flops. A
//   plain load is written in its accept cycle (unless the table is full)
//   and the block is ready again on the next one. A finished report, a
//   tick and a reconnect with a running action walk the table once, one
//   entry per cycle with registered read data. A selection (load with
//   last, or report or failing tick with entries left) makes a pass in
//   S_SEL, a write-back in S_WB and loads the result register in S_OUT;
//   with no candidate it returns to idle. One item at a time.
//   A result sits in an output register until taken; the next item is
//   accepted while it waits, and the block stalls only when a new result
//   would be produced while the old is still held.
//   Reset (i_rst_n low, synchronous) clears valid bits, tick counter, send
//   sequence and running action and loads the register defaults; no
//   clearing pass is needed.
// Depends on crs_pkg, crs_if and crs_table.
module command_retry_scheduler #(
    parameter int DEPTH = crs_pkg::DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    crs_in_if.sink    u_in,
    crs_out_if.source u_out,
    crs_cfg_if.sink   u_cfg
);
    import crs_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SEL, S_WB, S_OUT
    } t_state;

    // scan modes
    typedef enum logic [1:0] {
        M_LOAD, M_REPORT, M_TICK, M_RECON
    } t_mode;

    t_state r_state;
    t_mode  r_mode;
    logic [15:0] r_timeout;
    logic [3:0]  r_retry;
    logic        r_run_valid;
    logic [7:0]  r_run_type;
    logic [15:0] r_tick;
    logic [15:0] r_seq;
    logic [DEPTH-1:0] r_used;
    logic [CW-1:0] r_count;

    logic [7:0]  r_num;

    logic [AW:0] r_idx;        // issue index
    logic        r_rv;         // read data valid
    logic [AW-1:0] r_ridx;     // index of read data
    logic        r_hit;        // report matched / failed flag
    logic        r_incomp;     // incomplete entry seen
    logic        r_bvalid;
    logic [AW-1:0] r_bidx;
    t_entry      r_best;

    logic        r_ovalid;
    logic [1:0]  r_okind;
    logic [7:0]  r_onum;
    logic [15:0] r_opay;
    logic [7:0]  r_otype;
    logic [7:0]  r_osends;
    logic [4:0]  r_ocnt;

    logic [AW-1:0] raddr;
    t_entry rdata;
    logic we;
    logic [AW-1:0] waddr;
    t_entry wdata;

    crs_table #(.DEPTH(DEPTH)) u_table (
        .i_clk(i_clk), .i_raddr(raddr), .o_rdata(rdata),
        .i_we(we), .i_waddr(waddr), .i_wdata(wdata)
    );

    assign raddr = r_idx[AW-1:0];
    assign u_in.ready = (r_state == S_IDLE);
    assign u_cfg.ready = 1'b1;
    assign u_out.valid = r_ovalid;
    assign u_out.kind = r_okind;
    assign u_out.sent_number = r_onum;
    assign u_out.sent_payload = r_opay;
    assign u_out.running_type = r_otype;
    assign u_out.times_sent = r_osends;
    assign u_out.entry_count = r_ocnt;

    // entry under scan and its candidacy
    logic   used_i;
    t_entry cur;
    logic   cand;
    logic   better;
    logic [15:0] age_e, age_b, age_t;
    t_entry tick_e;
    logic   tick_upd, tick_fail;
    logic [3:0] to_n;

    always_comb begin
        used_i = r_used[r_ridx];
        cur = rdata;
        cand = used_i && !cur.done && (cur.timeouts < r_retry);
        age_e = r_seq - cur.order;
        age_b = r_seq - r_best.order;
        if (!r_bvalid) better = 1'b1;
        else if (!cur.sent && r_best.sent) better = 1'b1;
        else if (cur.sent && !r_best.sent) better = 1'b0;
        else if (!cur.sent) begin
            if (cur.sends != r_best.sends) better = cur.sends < r_best.sends;
            else better = cur.number < r_best.number;
        end else better = age_e > age_b;
        age_t = r_tick - cur.stamp;
        tick_e = cur;
        tick_upd = used_i && !cur.done && cur.sent && (age_t > r_timeout);
        to_n = (cur.timeouts < 4'd15) ? cur.timeouts + 4'd1 : cur.timeouts;
        tick_fail = tick_upd && (to_n >= r_retry);
        tick_e.timeouts = to_n;
        if (tick_fail) tick_e.done = 1'b1;
        else tick_e.sent = 1'b0;
    end

    logic scan_end;
    assign scan_end = r_rv && (r_ridx == AW'(DEPTH - 1));

    // lowest free slot from valid bits
    logic [AW-1:0] free_idx;
    always_comb begin
        free_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!r_used[i]) free_idx = AW'(i);
        end
    end

    always_comb begin
        we = 1'b0;
        waddr = r_ridx;
        wdata = cur;
        if (r_state == S_SCAN && r_rv) begin
            if (r_mode == M_REPORT && used_i && cur.number == r_num && !r_hit) begin
                we = 1'b1;
                wdata.done = 1'b1;
            end else if (r_mode == M_TICK && tick_upd) begin
                we = 1'b1;
                wdata = tick_e;
            end
        end else if (r_state == S_WB) begin
            we = 1'b1;
            waddr = r_bidx;
            wdata = r_best;
            wdata.sent = 1'b1;
            wdata.stamp = r_tick;
            wdata.order = r_seq;
            wdata.sends = (r_best.sends != 8'hFF) ? r_best.sends + 8'd1 : r_best.sends;
        end else if (r_state == S_IDLE && u_in.valid && u_in.ready
                     && t_func'(u_in.func) == F_LOAD) begin
            we = (r_count != CW'(DEPTH));
            waddr = free_idx;
            wdata = '0;
            wdata.number = u_in.cmd_num;
            wdata.atype = u_in.action_type;
            wdata.payload = u_in.payload_ref;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode <= M_LOAD;
            r_timeout <= TIMEOUT_RST;
            r_retry <= RETRY_RST;
            r_run_valid <= 1'b0;
            r_run_type <= '0;
            r_tick <= '0;
            r_seq <= '0;
            r_used <= '0;
            r_count <= '0;
            r_ovalid <= 1'b0;
            r_rv <= 1'b0;
            r_idx <= '0;
        end else begin
            if (u_cfg.valid) begin
                if (u_cfg.index == CFG_TIMEOUT) r_timeout <= u_cfg.data;
                else r_retry <= u_cfg.data[3:0];
            end
            if (u_out.ready && r_state != S_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (u_in.valid && u_in.ready) begin
                        r_num <= u_in.cmd_num;
                        r_hit <= 1'b0;
                        r_incomp <= 1'b0;
                        r_bvalid <= 1'b0;
                        r_idx <= '0;
                        r_rv <= 1'b0;
                        unique case (t_func'(u_in.func))
                            F_LOAD: begin
                                if (r_count != CW'(DEPTH)) begin
                                    r_used[free_idx] <= 1'b1;
                                    r_count <= r_count + CW'(1);
                                end
                                r_mode <= M_LOAD;
                                if (u_in.last) begin
                                    r_state <= S_SEL;
                                end
                            end
                            F_REPORT: begin
                                r_mode <= M_REPORT;
                                if (u_in.finished) r_state <= S_SCAN;
                            end
                            F_TICK: begin
                                r_mode <= M_TICK;
                                r_tick <= r_tick + 16'd1;
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_mode <= M_RECON;
                                if (r_run_valid) r_state <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_SCAN, S_SEL: begin
                    if (!scan_end) begin
                        if (r_idx != (AW+1)'(DEPTH)) r_idx <= r_idx + (AW+1)'(1);
                        r_rv <= (r_idx != (AW+1)'(DEPTH));
                    end
                    r_ridx <= r_idx[AW-1:0];
                    if (r_rv) begin
                        if (r_state == S_SEL) begin
                            if (cand && better) begin
                                r_bvalid <= 1'b1;
                                r_bidx <= r_ridx;
                                r_best <= cur;
                            end
                        end else begin
                            unique case (r_mode)
                                M_REPORT: begin
                                    if (used_i && cur.number == r_num) r_hit <= 1'b1;
                                    if (used_i && !cur.done
                                        && !(cur.number == r_num && !r_hit))
                                        r_incomp <= 1'b1;
                                end
                                M_TICK: begin
                                    if (tick_fail) r_hit <= 1'b1;
                                    if (used_i && !cur.done && !tick_fail)
                                        r_incomp <= 1'b1;
                                end
                                M_RECON: begin
                                    if (used_i && !cur.done && cur.atype == r_run_type
                                        && (!r_bvalid || cur.number < r_best.number)) begin
                                        r_bvalid <= 1'b1;
                                        r_best <= cur;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    if (scan_end) begin
                        r_idx <= '0;
                        r_rv <= 1'b0;
                        if (r_state == S_SEL) begin
                            if ((cand && better) || r_bvalid) r_state <= S_WB;
                            else r_state <= S_IDLE;
                        end else begin
                            unique case (r_mode)
                                M_RECON: begin
                                    if (r_bvalid || (used_i && !cur.done
                                        && cur.atype == r_run_type))
                                        r_state <= S_OUT;
                                    else r_state <= S_IDLE;
                                end
                                M_TICK: begin
                                    if (r_hit || tick_fail) begin
                                        if (r_incomp || (used_i && !cur.done && !tick_fail))
                                            r_state <= S_SEL;
                                        else r_state <= S_OUT;
                                    end else r_state <= S_IDLE;
                                end
                                default: begin
                                    if (r_incomp || (used_i && !cur.done
                                        && !(cur.number == r_num && !r_hit)))
                                        r_state <= S_SEL;
                                    else r_state <= S_OUT;
                                end
                            endcase
                        end
                    end
                end
                S_WB: begin
                    r_run_valid <= 1'b1;
                    r_run_type <= r_best.atype;
                    r_seq <= r_seq + 16'd1;
                    r_state <= S_OUT;
                    r_mode <= M_LOAD;
                end
                S_OUT: begin
                    if (!r_ovalid || u_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                        if (r_mode == M_RECON) begin
                            r_okind <= K_RESEND;
                            r_onum <= r_best.number;
                            r_opay <= r_best.payload;
                            r_otype <= r_run_type;
                            r_osends <= r_best.sends;
                            r_ocnt <= 5'(r_count);
                        end else if (r_mode == M_LOAD) begin
                            r_okind <= K_SEND;
                            r_onum <= r_best.number;
                            r_opay <= r_best.payload;
                            r_otype <= r_best.atype;
                            r_osends <= (r_best.sends != 8'hFF) ? r_best.sends + 8'd1
                                                               : r_best.sends;
                            r_ocnt <= 5'(r_count);
                        end else begin
                            r_okind <= K_DONE;
                            r_onum <= '0;
                            r_opay <= '0;
                            r_otype <= r_run_valid ? r_run_type : 8'd0;
                            r_osends <= '0;
                            r_ocnt <= '0;
                            r_used <= '0;
                            r_count <= '0;
                            r_run_valid <= 1'b0;
                            r_run_type <= '0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(r_used)))
        else $error("count mismatch");
    a_wb_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WB |-> r_bvalid)
        else $error("write-back without candidate");
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WB |=> r_seq == $past(r_seq) + 16'd1)
        else $error("sequence not advanced");
`endif
endmodule

/* tb/crs_checker.sv */
// Checker for the command retry scheduler: watches the item, result and register channels,
// predicts every result and compares it field by field in arrival order.
// Depends on crs_pkg and crs_if.
module crs_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    crs_in_if         u_in,
    crs_out_if        u_out,
    crs_cfg_if        u_cfg,
    output int        o_fails,
    output int        o_pending
);
    import crs_pkg::*;

    localparam int NSLOT = DEPTH_DEF;

    typedef struct {
        t_kind      kind;
        logic [7:0] number;
        logic [15:0] payload;
        logic [7:0] rtype;
        logic [7:0] sends;
        logic [4:0] count;
    } t_result;

    t_result     sched_q[$];
    logic        s_used [NSLOT];
    logic        s_done [NSLOT];
    logic        s_sent [NSLOT];
    logic [7:0]  s_num  [NSLOT];
    logic [7:0]  s_type [NSLOT];
    logic [15:0] s_pay  [NSLOT];
    logic [15:0] s_ord  [NSLOT];
    logic [15:0] s_stamp[NSLOT];
    logic [7:0]  s_sends[NSLOT];
    logic [3:0]  s_tmo  [NSLOT];
    logic [15:0] timeout_ticks;
    logic [3:0]  max_retries;
    logic        run_valid;
    logic [7:0]  run_type;
    logic [15:0] tick_now;
    logic [15:0] send_seq;

    assign o_pending = sched_q.size();

    function automatic logic [4:0] used_count();
        logic [4:0] n;
        n = 0;
        for (int i = 0; i < NSLOT; i++) if (s_used[i]) n++;
        return n;
    endfunction

    function automatic void push_result(t_kind k, logic [7:0] n, logic [15:0] p,
                                        logic [7:0] t, logic [7:0] c);
        t_result r;
        r.kind = k; r.number = n; r.payload = p; r.rtype = t; r.sends = c;
        r.count = used_count();
        sched_q.insert(sched_q.size(), r);
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < NSLOT; i++) begin
            s_used[i] = 0; s_done[i] = 0; s_sent[i] = 0; s_num[i] = 0; s_type[i] = 0;
            s_pay[i] = 0; s_ord[i] = 0; s_stamp[i] = 0; s_sends[i] = 0; s_tmo[i] = 0;
        end
    endfunction

    function automatic void send_next();
        int best;
        logic better;
        logic [15:0] ae, ab;
        best = -1;
        for (int i = 0; i < NSLOT; i++) begin
            if (!s_used[i] || s_done[i] || s_tmo[i] >= max_retries) continue;
            if (best < 0) begin
                best = i;
                continue;
            end
            if (!s_sent[i] && s_sent[best]) better = 1;
            else if (s_sent[i] && !s_sent[best]) better = 0;
            else if (!s_sent[i]) begin
                if (s_sends[i] != s_sends[best]) better = s_sends[i] < s_sends[best];
                else better = s_num[i] < s_num[best];
            end else begin
                ae = send_seq - s_ord[i];
                ab = send_seq - s_ord[best];
                better = ae > ab;
            end
            if (better) best = i;
        end
        if (best < 0) return;
        run_valid = 1;
        run_type = s_type[best];
        s_sent[best] = 1;
        s_stamp[best] = tick_now;
        s_ord[best] = send_seq;
        send_seq = send_seq + 16'd1;
        if (s_sends[best] != 8'hFF) s_sends[best]++;
        push_result(K_SEND, s_num[best], s_pay[best], s_type[best], s_sends[best]);
    endfunction

    function automatic void close_or_send();
        logic [7:0] t;
        for (int i = 0; i < NSLOT; i++) begin
            if (s_used[i] && !s_done[i]) begin
                send_next();
                return;
            end
        end
        t = run_valid ? run_type : 8'd0;
        clear_table();
        run_valid = 0;
        run_type = 0;
        push_result(K_DONE, 8'd0, 16'd0, t, 8'd0);
    endfunction

    function automatic void predict_item(t_func f, logic [7:0] n, logic [7:0] t,
                                         logic [15:0] p, logic l, logic fin);
        logic failed;
        int best;
        case (f)
            F_LOAD: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (!s_used[i]) begin
                        s_used[i] = 1; s_done[i] = 0; s_sent[i] = 0; s_num[i] = n;
                        s_type[i] = t; s_pay[i] = p; s_ord[i] = 0; s_stamp[i] = 0;
                        s_sends[i] = 0; s_tmo[i] = 0;
                        break;
                    end
                end
                if (l && used_count() > 0) send_next();
            end
            F_REPORT: begin
                if (fin) begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (s_used[i] && s_num[i] == n) begin
                            s_done[i] = 1;
                            break;
                        end
                    end
                    close_or_send();
                end
            end
            F_TICK: begin
                failed = 0;
                tick_now = tick_now + 16'd1;
                for (int i = 0; i < NSLOT; i++) begin
                    if (!s_used[i] || s_done[i] || !s_sent[i]) continue;
                    if (16'(tick_now - s_stamp[i]) > timeout_ticks) begin
                        if (s_tmo[i] != 4'hF) s_tmo[i]++;
                        if (s_tmo[i] >= max_retries) begin
                            s_done[i] = 1;
                            failed = 1;
                        end else begin
                            s_sent[i] = 0;
                        end
                    end
                end
                if (failed) close_or_send();
            end
            default: begin
                if (run_valid) begin
                    best = -1;
                    for (int i = 0; i < NSLOT; i++) begin
                        if (!s_used[i] || s_done[i] || s_type[i] != run_type) continue;
                        if (best < 0 || s_num[i] < s_num[best]) best = i;
                    end
                    if (best >= 0)
                        push_result(K_RESEND, s_num[best], s_pay[best], run_type,
                                    s_sends[best]);
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
        o_fails++;
    endtask

    always @(posedge i_clk) begin
        t_result w;
        if (!i_rst_n) begin
            o_fails = 0;
            clear_table();
            sched_q.delete();
            timeout_ticks = TIMEOUT_RST;
            max_retries = RETRY_RST;
            run_valid = 0;
            run_type = 0;
            tick_now = 0;
            send_seq = 0;
        end else begin
            if (u_out.valid && u_out.ready) begin
                if (sched_q.size() == 0) begin
                    report_mismatch("unexpected result kind", u_out.kind, 0);
                end else begin
                    w = sched_q.pop_front();
                    if (u_out.kind != w.kind) report_mismatch("kind", u_out.kind, w.kind);
                    if (u_out.sent_number != w.number)
                        report_mismatch("sent_number", u_out.sent_number, w.number);
                    if (u_out.sent_payload != w.payload)
                        report_mismatch("sent_payload", u_out.sent_payload, w.payload);
                    if (u_out.running_type != w.rtype)
                        report_mismatch("running_type", u_out.running_type, w.rtype);
                    if (u_out.times_sent != w.sends)
                        report_mismatch("times_sent", u_out.times_sent, w.sends);
                    if (u_out.entry_count != w.count)
                        report_mismatch("entry_count", u_out.entry_count, w.count);
                end
            end
            if (u_cfg.valid && u_cfg.ready) begin
                if (u_cfg.index == CFG_TIMEOUT) timeout_ticks = u_cfg.data;
                else max_retries = u_cfg.data[3:0];
            end
            if (u_in.valid && u_in.ready)
                predict_item(t_func'(u_in.func), u_in.cmd_num, u_in.action_type,
                             u_in.payload_ref, u_in.last, u_in.finished);
        end
    end
endmodule

/* tb/tb_command_retry_scheduler.sv */
// Top of the command retry scheduler testbench: clock, reset, stimulus and verdict.
// Drives directed and random items and register writes; crs_checker predicts and compares.
// Depends on crs_pkg, crs_if, command_retry_scheduler and crs_checker.
module tb_command_retry_scheduler;
    import crs_pkg::*;

    localparam int LIMIT = 3000000;
    localparam int SETTLE = 2 * DEPTH_DEF + 20;

    logic i_clk = 0;
    logic i_rst_n;
    int   fails, pending, cycles = 0;
    int   tx_idle = 10, rx_idle = 78;
    int   hold_cnt = 0;
    logic hold_go;
    int   n_items = 0;
    logic [7:0] batch_nums[$];

    crs_in_if  u_in_ch();
    crs_out_if u_out_ch();
    crs_cfg_if u_cfg_ch();

    command_retry_scheduler u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .u_in(u_in_ch.sink), .u_out(u_out_ch.source), .u_cfg(u_cfg_ch.sink)
    );

    crs_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .u_in(u_in_ch), .u_out(u_out_ch),
        .u_cfg(u_cfg_ch), .o_fails(fails), .o_pending(pending)
    );

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[command_retry_scheduler] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_go) hold_cnt <= 400;
        else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_go || hold_cnt != 0) u_out_ch.ready <= 0;
        else u_out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end

    task automatic put_item(t_func f, logic [7:0] n, logic [7:0] t, logic [15:0] p,
                            logic l, logic fin);
        if ($urandom_range(99) < tx_idle) begin
            u_in_ch.valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        u_in_ch.valid <= 1;
        u_in_ch.func <= f;
        u_in_ch.cmd_num <= n;
        u_in_ch.action_type <= t;
        u_in_ch.payload_ref <= p;
        u_in_ch.last <= l;
        u_in_ch.finished <= fin;
        do @(posedge i_clk); while (!u_in_ch.ready);
        n_items++;
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        u_in_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        u_cfg_ch.valid <= 1;
        u_cfg_ch.index <= idx;
        u_cfg_ch.data <= val;
        do @(posedge i_clk); while (!u_cfg_ch.ready);
        u_cfg_ch.valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic run_batch();
        int k, ev, r;
        logic [7:0] t;
        logic [7:0] n;
        r = $urandom_range(99);
        k = (r < 80) ? $urandom_range(1, 6) : (r < 90) ? $urandom_range(7, 16)
                                                       : $urandom_range(17, 19);
        t = 8'($urandom);
        batch_nums.delete();
        for (int i = 0; i < k; i++) begin
            n = ($urandom_range(3) == 0) ? 8'($urandom_range(7)) : 8'($urandom);
            batch_nums.insert(batch_nums.size(), n);
            put_item(F_LOAD, n, ($urandom_range(9) == 0) ? 8'($urandom) : t,
                     16'($urandom), (i == k - 1) || ($urandom_range(19) == 0),
                     1'($urandom));
        end
        ev = 3 * k + 2;
        for (int i = 0; i < ev; i++) begin
            r = $urandom_range(99);
            if (r < 45)
                put_item(F_REPORT, batch_nums[$urandom_range(batch_nums.size() - 1)],
                         8'($urandom), 16'($urandom), 1'($urandom), 1'b1);
            else if (r < 52)
                put_item(F_REPORT, 8'($urandom), 8'($urandom), 16'($urandom),
                         1'($urandom), 1'($urandom));
            else if (r < 85)
                put_item(F_TICK, 8'($urandom), 8'($urandom), 16'($urandom),
                         1'($urandom), 1'($urandom));
            else if (r < 95)
                put_item(F_RECONNECT, 8'($urandom), 8'($urandom), 16'($urandom),
                         1'($urandom), 1'($urandom));
            else
                put_item(t_func'($urandom_range(3)), 8'($urandom), 8'($urandom),
                         16'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    task automatic run_phase(int target, logic [15:0] tmo, logic [3:0] rty);
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_RETRY, {12'd0, rty});
        while (n_items < target) run_batch();
    endtask

    initial begin
        i_rst_n <= 0;
        hold_go <= 0;
        u_in_ch.valid <= 0;
        u_in_ch.func <= F_LOAD;
        u_in_ch.cmd_num <= 0;
        u_in_ch.action_type <= 0;
        u_in_ch.payload_ref <= 0;
        u_in_ch.last <= 0;
        u_in_ch.finished <= 0;
        u_cfg_ch.valid <= 0;
        u_cfg_ch.index <= CFG_TIMEOUT;
        u_cfg_ch.data <= 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        put_item(F_RECONNECT, 0, 0, 0, 0, 0);
        put_item(F_REPORT, 8'd5, 0, 0, 0, 0);
        put_item(F_REPORT, 8'd5, 0, 0, 0, 1);
        put_item(F_LOAD, 8'hFF, 8'hFF, 16'hFFFF, 0, 0);
        put_item(F_LOAD, 8'h00, 8'h00, 16'h0000, 0, 1);
        put_item(F_LOAD, 8'h00, 8'hFF, 16'h1234, 1, 0);
        put_item(F_RECONNECT, 8'hFF, 8'hFF, 16'hFFFF, 1, 1);
        put_item(F_REPORT, 8'h77, 0, 0, 0, 1);
        put_item(F_REPORT, 8'h00, 0, 0, 0, 1);
        for (int i = 0; i < 18; i++)
            put_item(F_LOAD, 8'(i % 3), 8'h5A, 16'(i), i == 17, 0);
        repeat (4) put_item(F_REPORT, 8'd1, 0, 0, 0, 1);

        tx_idle = 10; rx_idle = 78;
        run_phase(200, 16'd1, 4'd1);
        run_phase(330, 16'd3, 4'd15);
        tx_idle = 78; rx_idle = 10;
        run_phase(470, 16'hFFFF, 4'd2);
        run_phase(600, 16'd2, 4'd3);
        tx_idle = 0; rx_idle = 0;
        write_reg(CFG_TIMEOUT, 16'd30);
        write_reg(CFG_RETRY, 16'd15);
        hold_go <= 1;
        @(posedge i_clk);
        hold_go <= 0;
        while (n_items < 720) run_batch();
        run_phase(840, 16'd1, 4'd2);

        u_in_ch.valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fails == 0 && pending == 0)
            $display("[command_retry_scheduler] OK");
        else
            $display("[command_retry_scheduler] ERROR");
        $finish;
    end
endmodule
